@@ hw/rtl/pha_pkg.sv @@
`default_nettype none
package pha_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int CNT_W       = 40;
  localparam int OUT_W       = 40;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam logic [15:0] ETH_IPV4 = 16'h0800;

  localparam logic [1:0] REQ_PACKET = 2'd0;
  localparam logic [1:0] REQ_TICK   = 2'd1;
  localparam logic [1:0] REQ_WRITE  = 2'd2;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [OUT_W-1:0] out_cnt_t;

  // Everything one table slot holds.
  typedef struct packed {
    logic [31:0] addr;
    logic        valid;
    cnt_t        sent;
    cnt_t        recv;
  } cell_state_t;

  // Signals driven to every cell at once.
  typedef struct packed {
    logic        count_en;
    logic        shift;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] len;
    logic [31:0] wr_addr;
    logic        wr_valid;
  } cell_bcast_t;

  function automatic cnt_t sat_add(cnt_t acc, logic [15:0] len);
    logic [CNT_W:0] sum;
    sum = {1'b0, acc} + (CNT_W + 1)'(len);
    return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
  endfunction

  // Clips a counter to the report field width.
  function automatic out_cnt_t clip_out(cnt_t v);
    logic [63:0] w;
    w = 64'(v);
    return (w > 64'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : w[OUT_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/pha_if.sv @@
`default_nettype none
interface pha_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] eth_type;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [15:0] total_len;
  logic [3:0]  slot_index;
  logic [31:0] slot_addr;
  logic        slot_enable;

  modport source (output valid, req_type, eth_type, src_addr, dst_addr, total_len,
                  slot_index, slot_addr, slot_enable, input ready);
  modport sink   (input valid, req_type, eth_type, src_addr, dst_addr, total_len,
                  slot_index, slot_addr, slot_enable, output ready);
endinterface

interface pha_rpt_if;
  logic                     valid;
  logic                     ready;
  logic [31:0]              host_addr;
  logic                     host_valid;
  logic [pha_pkg::OUT_W-1:0] sent_total;
  logic [pha_pkg::OUT_W-1:0] recv_total;
  logic                     last_slot;

  modport source (output valid, host_addr, host_valid, sent_total, recv_total, last_slot,
                  input ready);
  modport sink   (input valid, host_addr, host_valid, sent_total, recv_total, last_slot,
                  output ready);
endinterface
`default_nettype wire

@@ hw/rtl/per_host_byte_accounting.sv @@
// Per-host byte accounting.
// Requests arrive on req_i: a packet header, a tick, or a table entry write.
// Packet and entry-write beats are absorbed without a report; a packet
// updates every matching slot in parallel, so packets and writes sustain
// one beat per cycle while no report is in progress.
// A tick starts a report on rpt_o: one beat per slot, slot 0 first, with
// last_slot set on the final one. The first beat is valid the cycle after
// the tick is taken. The slots form a ring of cells that rotates by one
// position per report beat, the counters of the slot leaving the head being
// cleared, so after TABLE_DEPTH beats the table is back in place and zeroed.
// While a report is in progress req_i.ready is low; when the receiver
// stalls, the ring holds and the current beat stays on rpt_o.
// Reset empties the table: all addresses, valid bits and counters are zero,
// and no report is pending.
`default_nettype none
module per_host_byte_accounting (
  input  wire         clk_i,
  input  wire         rst_ni,
  pha_req_if.sink     req_i,
  pha_rpt_if.source   rpt_o
);

  localparam int D = pha_pkg::TABLE_DEPTH;
  localparam int W = pha_pkg::IDX_W;

  logic         busy_q, busy_d;
  logic [W-1:0] cnt_q, cnt_d;

  pha_pkg::cell_bcast_t bcast;
  pha_pkg::cell_state_t state [D];
  pha_pkg::cell_state_t nb    [D];
  logic [D-1:0]         wr_sel;

  logic req_fire, rpt_fire, is_last;

  assign req_i.ready = !busy_q;
  assign req_fire    = req_i.valid && req_i.ready;
  assign rpt_fire    = rpt_o.valid && rpt_o.ready;
  assign is_last     = (cnt_q == W'(D - 1));

  always_comb begin
    bcast.count_en = req_fire && (req_i.req_type == pha_pkg::REQ_PACKET) &&
                     (req_i.eth_type == pha_pkg::ETH_IPV4);
    bcast.shift    = rpt_fire;
    bcast.src      = req_i.src_addr;
    bcast.dst      = req_i.dst_addr;
    bcast.len      = req_i.total_len;
    bcast.wr_addr  = req_i.slot_addr;
    bcast.wr_valid = req_i.slot_enable;
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (busy_q) begin
      if (rpt_fire) begin
        if (is_last) begin
          busy_d = 1'b0;
          cnt_d  = '0;
        end else begin
          cnt_d = cnt_q + W'(1);
        end
      end
    end else if (req_fire && (req_i.req_type == pha_pkg::REQ_TICK)) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  for (genvar k = 0; k < D; k++) begin : g_cell
    assign wr_sel[k] = req_fire && (req_i.req_type == pha_pkg::REQ_WRITE) &&
                       (32'(req_i.slot_index) == 32'(k));

    // The head slot wraps to the tail with its counters cleared.
    if (k == D - 1) begin : g_tail
      assign nb[k] = '{addr: state[0].addr, valid: state[0].valid, sent: '0, recv: '0};
    end else begin : g_body
      assign nb[k] = state[k+1];
    end

    pha_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .bcast_i  (bcast),
      .wr_sel_i (wr_sel[k]),
      .nb_i     (nb[k]),
      .state_o  (state[k])
    );
  end

  assign rpt_o.valid      = busy_q;
  assign rpt_o.host_addr  = state[0].addr;
  assign rpt_o.host_valid = state[0].valid;
  assign rpt_o.sent_total = pha_pkg::clip_out(state[0].sent);
  assign rpt_o.recv_total = pha_pkg::clip_out(state[0].recv);
  assign rpt_o.last_slot  = busy_q && is_last;

  a_last_ends_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rpt_fire && rpt_o.last_slot |=> !rpt_o.valid && req_i.ready)
    else $error("report did not end after the last slot");

  a_tick_starts_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire && (req_i.req_type == pha_pkg::REQ_TICK) |=> rpt_o.valid && (cnt_q == '0))
    else $error("tick did not start a report at slot zero");

  a_idle_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (cnt_q == '0))
    else $error("slot count not zero while idle");

  a_stall_holds_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rpt_o.valid && !rpt_o.ready |=> $stable(cnt_q))
    else $error("slot count moved during a stalled beat");

endmodule
`default_nettype wire

@@ hw/rtl/pha_cell.sv @@
`default_nettype none
module pha_cell (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire pha_pkg::cell_bcast_t bcast_i,
  input  wire                       wr_sel_i,
  input  wire pha_pkg::cell_state_t nb_i,
  output pha_pkg::cell_state_t      state_o
);

  pha_pkg::cell_state_t st_q, st_d;

  always_comb begin
    st_d = st_q;
    if (bcast_i.shift) begin
      st_d = nb_i;
    end else if (wr_sel_i) begin
      st_d.addr  = bcast_i.wr_addr;
      st_d.valid = bcast_i.wr_valid;
      st_d.sent  = '0;
      st_d.recv  = '0;
    end else if (bcast_i.count_en && st_q.valid) begin
      if (st_q.addr == bcast_i.src) begin
        st_d.sent = pha_pkg::sat_add(st_q.sent, bcast_i.len);
      end
      if (st_q.addr == bcast_i.dst) begin
        st_d.recv = pha_pkg::sat_add(st_q.recv, bcast_i.len);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

  assign state_o = st_q;

endmodule
`default_nettype wire
